/* design/cpo_pkg.sv */
package cpo_pkg;

  localparam int MAX_VERTICES = 16;
  localparam int COORD_BITS   = 16;

  localparam int ADDR_W = $clog2(MAX_VERTICES);
  localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
  localparam int VERT_W = 2 * COORD_BITS;
  localparam int AXIS_W = COORD_BITS + 1;
  localparam int PROD_W = 2 * COORD_BITS + 1;
  localparam int DOT_W  = 2 * COORD_BITS + 2;

  localparam int Q_DEPTH = 4;
  localparam int QA_W    = $clog2(Q_DEPTH);
  localparam int QC_W    = $clog2(Q_DEPTH + 1);

  // Polygon select codes
  localparam logic POLY_FIRST  = 1'b0;
  localparam logic POLY_SECOND = 1'b1;

  // One command from the front end to the test engine
  typedef struct packed {
    logic                  we;
    logic                  sel;
    logic [ADDR_W-1:0]     addr;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic                  run;
    logic [CNT_W-1:0]      n_a;
    logic [CNT_W-1:0]      n_b;
    logic                  ovf;
  } cpo_cmd_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_RD_I,
    B_RD_J,
    B_AXIS,
    B_V_RD,
    B_V_MUL,
    B_V_ADD,
    B_V_CMP,
    B_CHECK,
    B_FINISH
  } cpo_state_t;

endpackage

/* design/cpo_front.sv */
module cpo_front
  import cpo_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic                  in_func,
  input  logic [COORD_BITS-1:0] in_vertex_x,
  input  logic [COORD_BITS-1:0] in_vertex_y,
  input  logic                  in_last_vertex,
  output logic                  cmd_push,
  output cpo_cmd_t              cmd,
  input  logic                  cmd_full
);

  logic [CNT_W-1:0] cnt_a_r, cnt_a_nxt;
  logic [CNT_W-1:0] cnt_b_r, cnt_b_nxt;
  logic             ovf_r, ovf_nxt;
  logic [CNT_W-1:0] cnt_sel;
  logic             room;
  logic             ovf_upd;
  logic [CNT_W-1:0] cnt_a_upd;
  logic [CNT_W-1:0] cnt_b_upd;

  assign in_full  = cmd_full;
  assign cmd_push = in_push && !cmd_full;

  always_comb begin
    cnt_sel   = (in_func == POLY_SECOND) ? cnt_b_r : cnt_a_r;
    room      = cnt_sel < CNT_W'(MAX_VERTICES);
    ovf_upd   = ovf_r || !room;
    cnt_a_upd = cnt_a_r;
    cnt_b_upd = cnt_b_r;
    if (room && in_func == POLY_FIRST)  cnt_a_upd = cnt_a_r + CNT_W'(1);
    if (room && in_func == POLY_SECOND) cnt_b_upd = cnt_b_r + CNT_W'(1);

    cmd.we   = room;
    cmd.sel  = in_func;
    cmd.addr = cnt_sel[ADDR_W-1:0];
    cmd.x    = in_vertex_x;
    cmd.y    = in_vertex_y;
    cmd.run  = in_last_vertex;
    cmd.n_a  = cnt_a_upd;
    cmd.n_b  = cnt_b_upd;
    cmd.ovf  = ovf_upd;

    cnt_a_nxt = cnt_a_r;
    cnt_b_nxt = cnt_b_r;
    ovf_nxt   = ovf_r;
    if (cmd_push) begin
      if (in_last_vertex) begin
        // the pair is handed off: start the next one empty
        cnt_a_nxt = '0;
        cnt_b_nxt = '0;
        ovf_nxt   = 1'b0;
      end else begin
        cnt_a_nxt = cnt_a_upd;
        cnt_b_nxt = cnt_b_upd;
        ovf_nxt   = ovf_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_a_r <= '0;
      cnt_b_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      cnt_a_r <= cnt_a_nxt;
      cnt_b_r <= cnt_b_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_a_r <= CNT_W'(MAX_VERTICES) && cnt_b_r <= CNT_W'(MAX_VERTICES))
    else $error("vertex count beyond capacity");

endmodule

/* design/cpo_queue.sv */
module cpo_queue
  import cpo_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  cpo_cmd_t push_data,
  output logic     full,
  input  logic     pop,
  output cpo_cmd_t pop_data,
  output logic     empty
);

  cpo_cmd_t          slot_r [Q_DEPTH];
  logic [QA_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QA_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QC_W-1:0]   cnt_r, cnt_nxt;
  logic              do_push;
  logic              do_pop;

  assign full     = cnt_r == QC_W'(Q_DEPTH);
  assign empty    = cnt_r == '0;
  assign pop_data = slot_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push)
      wr_ptr_nxt = (wr_ptr_r == QA_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + QA_W'(1);
    if (do_pop)
      rd_ptr_nxt = (rd_ptr_r == QA_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + QA_W'(1);
    if (do_push && !do_pop)      cnt_nxt = cnt_r + QC_W'(1);
    else if (do_pop && !do_push) cnt_nxt = cnt_r - QC_W'(1);
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QC_W'(Q_DEPTH))
    else $error("queue occupancy beyond depth");

  a_q_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> !empty)
    else $error("queue empty after a lone push");

endmodule

/* design/cpo_back.sv */
module cpo_back
  import cpo_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  cpo_cmd_t q_cmd,
  input  logic     q_empty,
  output logic     q_pop,
  output logic     out_empty,
  input  logic     out_pop,
  output logic     out_overlap,
  output logic     out_vertex_overflow
);

  logic [VERT_W-1:0] mem_a [MAX_VERTICES];
  logic [VERT_W-1:0] mem_b [MAX_VERTICES];
  logic [VERT_W-1:0] rd_a_r, rd_b_r;
  logic [ADDR_W-1:0] rd_addr;
  logic              we_a, we_b;

  cpo_state_t state_r, state_nxt;

  logic [CNT_W-1:0]  n_a_r, n_a_nxt;
  logic [CNT_W-1:0]  n_b_r, n_b_nxt;
  logic              ovf_r, ovf_nxt;
  logic              overlap_r, overlap_nxt;
  logic [ADDR_W-1:0] i_r, i_nxt;
  logic [ADDR_W-1:0] k_r, k_nxt;
  logic              axis_side_r, axis_side_nxt;
  logic              vside_r, vside_nxt;

  logic signed [COORD_BITS-1:0] pi_x_r, pi_x_nxt;
  logic signed [COORD_BITS-1:0] pi_y_r, pi_y_nxt;
  logic signed [AXIS_W-1:0]     ax_r, ax_nxt;
  logic signed [AXIS_W-1:0]     ay_r, ay_nxt;
  logic signed [PROD_W-1:0]     px_r, px_nxt;
  logic signed [PROD_W-1:0]     py_r, py_nxt;
  logic signed [DOT_W-1:0]      dot_r, dot_nxt;
  logic signed [DOT_W-1:0]      a_min_r, a_min_nxt, a_max_r, a_max_nxt;
  logic signed [DOT_W-1:0]      b_min_r, b_min_nxt, b_max_r, b_max_nxt;

  logic out_valid_r, out_valid_nxt;
  logic out_ovl_r, out_ovl_nxt;
  logic out_ovf_r, out_ovf_nxt;

  logic                         slot_free;
  logic [CNT_W-1:0]             axis_n, vert_n;
  logic [CNT_W-1:0]             i_inc, k_inc;
  logic                         i_last, k_last;
  logic [ADDR_W-1:0]            j_addr;
  logic                         sep;
  logic [VERT_W-1:0]            axis_vert, proj_vert;
  logic signed [COORD_BITS-1:0] av_x, av_y, pv_x, pv_y;

  assign out_empty           = !out_valid_r;
  assign out_overlap         = out_ovl_r;
  assign out_vertex_overflow = out_ovf_r;
  assign slot_free           = !out_valid_r || out_pop;

  always_comb begin
    axis_n    = axis_side_r ? n_b_r : n_a_r;
    vert_n    = vside_r ? n_b_r : n_a_r;
    i_inc     = CNT_W'(i_r) + CNT_W'(1);
    k_inc     = CNT_W'(k_r) + CNT_W'(1);
    i_last    = !(i_inc < axis_n);
    k_last    = !(k_inc < vert_n);
    j_addr    = i_last ? '0 : i_inc[ADDR_W-1:0];
    sep       = (a_max_r < b_min_r) || (a_min_r > b_max_r);
    axis_vert = axis_side_r ? rd_b_r : rd_a_r;
    proj_vert = vside_r ? rd_b_r : rd_a_r;
    av_x      = axis_vert[VERT_W-1:COORD_BITS];
    av_y      = axis_vert[COORD_BITS-1:0];
    pv_x      = proj_vert[VERT_W-1:COORD_BITS];
    pv_y      = proj_vert[COORD_BITS-1:0];
  end

  always_comb begin : next_state
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (!q_empty && q_cmd.run) begin
          if (q_cmd.n_a == '0 || q_cmd.n_b == '0) state_nxt = B_FINISH;
          else                                     state_nxt = B_RD_I;
        end
      end
      B_RD_I:  state_nxt = B_RD_J;
      B_RD_J:  state_nxt = B_AXIS;
      B_AXIS:  state_nxt = B_V_RD;
      B_V_RD:  state_nxt = B_V_MUL;
      B_V_MUL: state_nxt = B_V_ADD;
      B_V_ADD: state_nxt = B_V_CMP;
      B_V_CMP: state_nxt = (k_last && vside_r) ? B_CHECK : B_V_RD;
      B_CHECK: state_nxt = (sep || (i_last && axis_side_r)) ? B_FINISH : B_RD_I;
      B_FINISH: begin
        if (slot_free) state_nxt = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin : datapath
    q_pop         = 1'b0;
    we_a          = 1'b0;
    we_b          = 1'b0;
    rd_addr       = i_r;
    n_a_nxt       = n_a_r;
    n_b_nxt       = n_b_r;
    ovf_nxt       = ovf_r;
    overlap_nxt   = overlap_r;
    i_nxt         = i_r;
    k_nxt         = k_r;
    axis_side_nxt = axis_side_r;
    vside_nxt     = vside_r;
    pi_x_nxt      = pi_x_r;
    pi_y_nxt      = pi_y_r;
    ax_nxt        = ax_r;
    ay_nxt        = ay_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    dot_nxt       = dot_r;
    a_min_nxt     = a_min_r;
    a_max_nxt     = a_max_r;
    b_min_nxt     = b_min_r;
    b_max_nxt     = b_max_r;
    out_valid_nxt = out_valid_r && !out_pop;
    out_ovl_nxt   = out_ovl_r;
    out_ovf_nxt   = out_ovf_r;

    case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          we_a  = q_cmd.we && (q_cmd.sel == POLY_FIRST);
          we_b  = q_cmd.we && (q_cmd.sel == POLY_SECOND);
          if (q_cmd.run) begin
            n_a_nxt       = q_cmd.n_a;
            n_b_nxt       = q_cmd.n_b;
            ovf_nxt       = q_cmd.ovf;
            // with an empty polygon only two empty polygons overlap
            overlap_nxt   = (q_cmd.n_a == '0) && (q_cmd.n_b == '0);
            i_nxt         = '0;
            axis_side_nxt = POLY_FIRST;
          end
        end
      end
      B_RD_I: rd_addr = i_r;
      B_RD_J: begin
        rd_addr  = j_addr;
        pi_x_nxt = av_x;
        pi_y_nxt = av_y;
      end
      B_AXIS: begin
        // normal of edge i -> j: (-ey, ex)
        ax_nxt    = $signed({pi_y_r[COORD_BITS-1], pi_y_r}) - $signed({av_y[COORD_BITS-1], av_y});
        ay_nxt    = $signed({av_x[COORD_BITS-1], av_x}) - $signed({pi_x_r[COORD_BITS-1], pi_x_r});
        k_nxt     = '0;
        vside_nxt = POLY_FIRST;
      end
      B_V_RD: rd_addr = k_r;
      B_V_MUL: begin
        px_nxt = ax_r * pv_x;
        py_nxt = ay_r * pv_y;
      end
      B_V_ADD: begin
        dot_nxt = $signed({px_r[PROD_W-1], px_r}) + $signed({py_r[PROD_W-1], py_r});
      end
      B_V_CMP: begin
        if (vside_r == POLY_FIRST) begin
          if (k_r == '0 || dot_r < a_min_r) a_min_nxt = dot_r;
          if (k_r == '0 || dot_r > a_max_r) a_max_nxt = dot_r;
        end else begin
          if (k_r == '0 || dot_r < b_min_r) b_min_nxt = dot_r;
          if (k_r == '0 || dot_r > b_max_r) b_max_nxt = dot_r;
        end
        if (!k_last) begin
          k_nxt = k_inc[ADDR_W-1:0];
        end else if (vside_r == POLY_FIRST) begin
          k_nxt     = '0;
          vside_nxt = POLY_SECOND;
        end
      end
      B_CHECK: begin
        if (sep) begin
          overlap_nxt = 1'b0;
        end else if (!i_last) begin
          i_nxt = i_inc[ADDR_W-1:0];
        end else if (axis_side_r == POLY_FIRST) begin
          i_nxt         = '0;
          axis_side_nxt = POLY_SECOND;
        end else begin
          overlap_nxt = 1'b1;
        end
      end
      B_FINISH: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_ovl_nxt   = overlap_r;
          out_ovf_nxt   = ovf_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we_a) mem_a[q_cmd.addr] <= {q_cmd.x, q_cmd.y};
    if (we_b) mem_b[q_cmd.addr] <= {q_cmd.x, q_cmd.y};
    rd_a_r <= mem_a[rd_addr];
    rd_b_r <= mem_b[rd_addr];
  end

  always_ff @(posedge clk) begin
    n_a_r       <= n_a_nxt;
    n_b_r       <= n_b_nxt;
    ovf_r       <= ovf_nxt;
    overlap_r   <= overlap_nxt;
    i_r         <= i_nxt;
    k_r         <= k_nxt;
    axis_side_r <= axis_side_nxt;
    vside_r     <= vside_nxt;
    pi_x_r      <= pi_x_nxt;
    pi_y_r      <= pi_y_nxt;
    ax_r        <= ax_nxt;
    ay_r        <= ay_nxt;
    px_r        <= px_nxt;
    py_r        <= py_nxt;
    dot_r       <= dot_nxt;
    a_min_r     <= a_min_nxt;
    a_max_r     <= a_max_nxt;
    b_min_r     <= b_min_nxt;
    b_max_r     <= b_max_nxt;
    out_ovl_r   <= out_ovl_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_V_RD) |-> (CNT_W'(k_r) < vert_n))
    else $error("projection index past polygon size");

  a_finish_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_FINISH && slot_free) |=> (out_valid_r && state_r == B_IDLE))
    else $error("finished test did not reach the result register");

endmodule

/* design/convex_polygon_overlap_sat_unit.sv */
// Separating-axis overlap test for two convex polygons. Push one vertex per
// transaction (in_func picks the polygon, in_last_vertex closes the pair); up
// to 16 vertices per polygon are kept and any beyond that are dropped and
// reported in out_vertex_overflow. Vertex loads go in at one per cycle
// through a 4-entry command queue, so loading continues while a test runs
// until the queue fills. The test itself is a single shared projection unit
// reading both vertex RAMs through one port each; it stops at the first
// separating axis and skips the projections when either polygon is empty. One
// result per pair is then posted in a result register that holds until popped.
module convex_polygon_overlap_sat_unit
  import cpo_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic                  in_func,
  input  logic [COORD_BITS-1:0] in_vertex_x,
  input  logic [COORD_BITS-1:0] in_vertex_y,
  input  logic                  in_last_vertex,
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic                  out_overlap,
  output logic                  out_vertex_overflow
);

  cpo_cmd_t push_cmd;
  cpo_cmd_t head_cmd;
  logic     cmd_push;
  logic     q_full;
  logic     q_empty;
  logic     q_pop;

  cpo_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_func        (in_func),
    .in_vertex_x    (in_vertex_x),
    .in_vertex_y    (in_vertex_y),
    .in_last_vertex (in_last_vertex),
    .cmd_push       (cmd_push),
    .cmd            (push_cmd),
    .cmd_full       (q_full)
  );

  cpo_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_data (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (head_cmd),
    .empty     (q_empty)
  );

  cpo_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_cmd               (head_cmd),
    .q_empty             (q_empty),
    .q_pop               (q_pop),
    .out_empty           (out_empty),
    .out_pop             (out_pop),
    .out_overlap         (out_overlap),
    .out_vertex_overflow (out_vertex_overflow)
  );

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;
  import cpo_pkg::*;

  localparam int  RANDOM_ITEMS = 1050;
  localparam int  CYCLE_LIMIT  = 2000000;
  localparam int  TAIL_CYCLES  = 4500;
  localparam int  GEN_MAX      = 24;
  localparam real PI           = 3.14159265358979;

  typedef struct packed {
    logic                  func;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic                  last;
  } vertex_t;

  typedef struct packed {
    logic overlap;
    logic overflow;
  } verdict_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_push = 1'b0;
  logic                  in_full;
  logic                  in_func = 1'b0;
  logic [COORD_BITS-1:0] in_vertex_x = '0;
  logic [COORD_BITS-1:0] in_vertex_y = '0;
  logic                  in_last_vertex = 1'b0;
  logic                  out_empty;
  logic                  out_pop = 1'b0;
  logic                  out_overlap;
  logic                  out_vertex_overflow;

  vertex_t  vertex_feed[$];
  verdict_t verdicts_due[$];

  // predictor copy of the two vertex stores
  longint stored_x[2][MAX_VERTICES];
  longint stored_y[2][MAX_VERTICES];
  int     poly_cnt[2];
  bit     ovf_seen;

  // scratch polygons built by the stimulus generators
  int gen_x[2][GEN_MAX];
  int gen_y[2][GEN_MAX];
  int gen_n[2];

  int fault_count = 0;
  int cycle_count = 0;
  int gap_left = 0;
  int burst_left = 0;
  int hold_left = 0;
  int mode_left = 0;
  int stall_mode = 0;

  convex_polygon_overlap_sat_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_func            (in_func),
    .in_vertex_x        (in_vertex_x),
    .in_vertex_y        (in_vertex_y),
    .in_last_vertex     (in_last_vertex),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_overlap        (out_overlap),
    .out_vertex_overflow(out_vertex_overflow)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // true if an edge normal of polygon p leaves a strict gap to polygon q, or q is empty and p is not
  function automatic bit axes_split(int p, int q);
    int     np;
    int     nq;
    int     j;
    longint ax;
    longint ay;
    longint d;
    longint pmin;
    longint pmax;
    longint qmin;
    longint qmax;
    np = poly_cnt[p];
    nq = poly_cnt[q];
    for (int i = 0; i < np; i++) begin
      j = (i + 1 < np) ? i + 1 : 0;
      ax = -(stored_y[p][j] - stored_y[p][i]);
      ay = stored_x[p][j] - stored_x[p][i];
      if (nq == 0) return 1'b1;
      pmin = 0;
      pmax = 0;
      qmin = 0;
      qmax = 0;
      for (int k = 0; k < np; k++) begin
        d = ax * stored_x[p][k] + ay * stored_y[p][k];
        if (k == 0 || d < pmin) pmin = d;
        if (k == 0 || d > pmax) pmax = d;
      end
      for (int k = 0; k < nq; k++) begin
        d = ax * stored_x[q][k] + ay * stored_y[q][k];
        if (k == 0 || d < qmin) qmin = d;
        if (k == 0 || d > qmax) qmax = d;
      end
      if (pmax < qmin || pmin > qmax) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic int polygon_size();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 80) return $urandom_range(3, 6);
    if (pick < 95) return $urandom_range(7, 16);
    return $urandom_range(17, 20);
  endfunction

  function automatic int extreme_coord();
    case ($urandom_range(0, 6))
      0: return -32768;
      1: return -32767;
      2: return -1;
      3: return 0;
      4: return 1;
      5: return 32766;
      default: return 32767;
    endcase
  endfunction

  task automatic add_vertex(input bit func, input int x, input int y, input bit last);
    vertex_t v;
    v.func = func;
    v.x    = x[COORD_BITS-1:0];
    v.y    = y[COORD_BITS-1:0];
    v.last = last;
    vertex_feed.push_back(v);
  endtask

  // points on a circle at increasing angles form a convex ring
  task automatic ring_polygon(input int p, input int n, input int cx, input int cy,
                              input int r);
    int  steps[GEN_MAX];
    int  total;
    int  acc;
    real a0;
    real ang;
    total = 0;
    for (int k = 0; k < n; k++) begin
      steps[k] = $urandom_range(1, 60);
      total += steps[k];
    end
    a0  = $urandom_range(0, 359) * PI / 180.0;
    acc = 0;
    for (int k = 0; k < n; k++) begin
      ang = a0 + 2.0 * PI * acc / total;
      gen_x[p][k] = cx + $rtoi(r * $cos(ang));
      gen_y[p][k] = cy + $rtoi(r * $sin(ang));
      acc += steps[k];
    end
    gen_n[p] = n;
  endtask

  task automatic set_box(input int p, input int x0, input int y0, input int w, input int h);
    gen_x[p][0] = x0;
    gen_y[p][0] = y0;
    gen_x[p][1] = x0 + w;
    gen_y[p][1] = y0;
    gen_x[p][2] = x0 + w;
    gen_y[p][2] = y0 + h;
    gen_x[p][3] = x0;
    gen_y[p][3] = y0 + h;
    gen_n[p] = 4;
  endtask

  // queue both scratch polygons, in order or interleaved, with the mark on the final vertex
  task automatic emit_pair();
    int i0;
    int i1;
    int total;
    int order;
    int p;
    i0 = 0;
    i1 = 0;
    total = gen_n[0] + gen_n[1];
    order = $urandom_range(0, 2);
    while (i0 + i1 < total) begin
      if (i0 == gen_n[0]) p = 1;
      else if (i1 == gen_n[1]) p = 0;
      else if (order == 2) p = $urandom_range(0, 1);
      else p = order;
      if (p == 0) begin
        add_vertex(POLY_FIRST, gen_x[0][i0], gen_y[0][i0], i0 + i1 + 1 == total);
        i0++;
      end else begin
        add_vertex(POLY_SECOND, gen_x[1][i1], gen_y[1][i1], i0 + i1 + 1 == total);
        i1++;
      end
    end
  endtask

  initial begin
    int kind;
    int r0;
    int r1;
    int cx0;
    int cy0;
    int cx1;
    int cy1;
    int span;
    int m;
    int g;
    int w;
    int h;
    int bx;
    int by;
    int directed_items;

    // lone vertex of the second polygon, first polygon empty
    add_vertex(POLY_SECOND, 100, -100, 1'b1);
    // full-range triangles sharing their diagonal: touching
    add_vertex(POLY_FIRST, -32768, -32768, 1'b0);
    add_vertex(POLY_FIRST, 32767, -32768, 1'b0);
    add_vertex(POLY_FIRST, 32767, 32767, 1'b0);
    add_vertex(POLY_SECOND, 32767, 32767, 1'b0);
    add_vertex(POLY_SECOND, -32768, 32767, 1'b0);
    add_vertex(POLY_SECOND, -32768, -32768, 1'b1);
    // repeated point: zero-length edges only
    add_vertex(POLY_FIRST, 5, 5, 1'b0);
    add_vertex(POLY_FIRST, 5, 5, 1'b0);
    add_vertex(POLY_SECOND, 5, 5, 1'b1);
    // one vertex past the store capacity
    ring_polygon(0, MAX_VERTICES + 1, 0, 0, 30000);
    gen_n[1]    = 1;
    gen_x[1][0] = 0;
    gen_y[1][0] = 0;
    emit_pair();
    directed_items = vertex_feed.size();

    while (vertex_feed.size() < directed_items + RANDOM_ITEMS) begin
      kind = $urandom_range(0, 99);
      if (kind < 65) begin
        if ($urandom_range(0, 3) == 0) begin
          r0 = $urandom_range(2, 60);
          r1 = $urandom_range(2, 60);
        end else begin
          r0 = $urandom_range(100, 6000);
          r1 = $urandom_range(100, 6000);
        end
        span = (3 * (r0 + r1)) / 2;
        cx0 = int'($urandom_range(0, 24000)) - 12000;
        cy0 = int'($urandom_range(0, 24000)) - 12000;
        cx1 = cx0 + int'($urandom_range(0, 2 * span)) - span;
        cy1 = cy0 + int'($urandom_range(0, 2 * span)) - span;
        if (cx1 > 26000) cx1 = 26000;
        if (cx1 < -26000) cx1 = -26000;
        if (cy1 > 26000) cy1 = 26000;
        if (cy1 < -26000) cy1 = -26000;
        ring_polygon(0, polygon_size(), cx0, cy0, r0);
        ring_polygon(1, polygon_size(), cx1, cy1, r1);
        emit_pair();
      end else if (kind < 77) begin
        // boxes that touch, overlap by one LSB, or miss by one LSB
        bx = int'($urandom_range(0, 40000)) - 20000;
        by = int'($urandom_range(0, 40000)) - 20000;
        w  = $urandom_range(1, 4000);
        h  = $urandom_range(1, 4000);
        g  = int'($urandom_range(0, 2)) - 1;
        set_box(0, bx, by, w, h);
        if ($urandom_range(0, 1) == 0)
          set_box(1, bx + w + g, by + int'($urandom_range(0, h)) - h / 2,
                  $urandom_range(1, 4000), $urandom_range(1, 4000));
        else
          set_box(1, bx + int'($urandom_range(0, w)) - w / 2, by + h + g,
                  $urandom_range(1, 4000), $urandom_range(1, 4000));
        emit_pair();
      end else if (kind < 87) begin
        for (int p = 0; p < 2; p++) begin
          gen_n[p] = $urandom_range(1, 4);
          for (int k = 0; k < gen_n[p]; k++) begin
            gen_x[p][k] = extreme_coord();
            gen_y[p][k] = extreme_coord();
          end
        end
        emit_pair();
      end else begin
        // noise: arbitrary vertices, sometimes closed early
        m = $urandom_range(1, 10);
        for (int k = 0; k < m; k++)
          add_vertex($urandom_range(0, 1), $urandom_range(0, 65535), $urandom_range(0, 65535),
                     k == m - 1 || $urandom_range(0, 7) == 0);
      end
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (vertex_feed.size() != 0 || verdicts_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fault_count == 0 && verdicts_due.size() == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

  // sender: bursts of pushes separated by random gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else if (gap_left != 0) begin
      in_push  <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (vertex_feed.size() == 0) begin
      in_push <= 1'b0;
    end else begin
      in_push        <= 1'b1;
      in_func        <= vertex_feed[0].func;
      in_vertex_x    <= vertex_feed[0].x;
      in_vertex_y    <= vertex_feed[0].y;
      in_last_vertex <= vertex_feed[0].last;
      if (burst_left <= 1) begin
        burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
                                                  : $urandom_range(1, 12);
        gap_left   <= $urandom_range(0, 8);
      end else begin
        burst_left <= burst_left - 1;
      end
    end
  end

  // receiver: pops with holds whose length depends on a randomly chosen stall mode
  always @(negedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        mode_left  <= $urandom_range(50, 600);
      end else begin
        mode_left <= mode_left - 1;
      end
      if (hold_left != 0) begin
        out_pop   <= 1'b0;
        hold_left <= hold_left - 1;
      end else begin
        out_pop <= 1'b1;
        if (stall_mode != 0 && $urandom_range(0, 2) == 0)
          hold_left <= (stall_mode == 1) ? $urandom_range(1, 3) : $urandom_range(5, 40);
      end
    end
  end

  // check popped verdicts first, then predict from the accepted vertex
  always @(posedge clk) begin : watch_ports
    verdict_t want;
    vertex_t  sent;
    bit       split;
    if (!rst_n) begin
      poly_cnt[0] = 0;
      poly_cnt[1] = 0;
      ovf_seen    = 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (verdicts_due.size() == 0) begin
          if (fault_count < 10)
            $display("unexpected verdict: overlap %0b overflow %0b",
                     out_overlap, out_vertex_overflow);
          fault_count++;
        end else begin
          want = verdicts_due.pop_front();
          if (want.overlap !== out_overlap || want.overflow !== out_vertex_overflow) begin
            if (fault_count < 10)
              $display("mismatch: overlap exp %0b got %0b, overflow exp %0b got %0b",
                       want.overlap, out_overlap, want.overflow, out_vertex_overflow);
            fault_count++;
          end
        end
      end
      if (in_push && !in_full) begin
        sent = vertex_feed.pop_front();
        if (poly_cnt[sent.func] < MAX_VERTICES) begin
          stored_x[sent.func][poly_cnt[sent.func]] = longint'($signed(sent.x));
          stored_y[sent.func][poly_cnt[sent.func]] = longint'($signed(sent.y));
          poly_cnt[sent.func]++;
        end else begin
          ovf_seen = 1'b1;
        end
        if (sent.last) begin
          split = axes_split(0, 1) || axes_split(1, 0);
          want.overlap  = !split;
          want.overflow = ovf_seen;
          verdicts_due.push_back(want);
          poly_cnt[0] = 0;
          poly_cnt[1] = 0;
          ovf_seen    = 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

endmodule
